// ===== hdl/fsgs_pkg.sv =====
// shared types, codes and constants of the falling sand grid sweep
`timescale 1ns / 1ps
`default_nettype none
package fsgs_pkg;

    localparam int CW          = 8;     // coordinate width on the stream
    localparam int COLW        = 24;    // packed rgb colour
    localparam int PERW        = 8;     // sweep period / frame counter
    localparam int MW          = COLW + 1;  // stored cell: solid bit over colour
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 32;
    localparam int GRID_X_DEF  = 64;
    localparam int GRID_Y_DEF  = 64;
    localparam logic [COLW-1:0] RESET_COLOR = 24'hB46400;
    localparam logic [PERW-1:0] PERIOD_RESET = 8'd1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DECODE,
        S_SW_INIT,
        S_SW_RC,
        S_SW_EC,
        S_SW_ED,
        S_SW_EDR,
        S_SW_EDL,
        S_SW_WS,
        S_SW_NEXT,
        S_OUT_RD,
        S_OUT_FR,
        S_OUT_SW
    } t_state;

    // memory address source
    typedef enum logic [2:0] {
        A_CLR,
        A_IN,
        A_C,
        A_D,
        A_DR,
        A_DL
    } t_asel;

    // memory write data source
    typedef enum logic [1:0] {
        W_CLEAR,
        W_PAINT,
        W_DST,
        W_SRC
    } t_wsel;

    // result item source
    typedef enum logic [1:0] {
        O_READ,
        O_FRAME,
        O_SWEPT
    } t_osel;

    typedef struct packed {
        logic  load_in;
        logic  cnt_upd;
        logic  mem_we;
        t_wsel wsel;
        t_asel asel;
        logic  clr_inc;
        logic  sw_init;
        logic  keep_color;
        logic  set_cur_mv;
        logic  set_nxt_mv;
        logic  step;
        logic  out_load;
        t_osel osel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic paint_ok;
        logic sweep_go;
        logic clr_last;
        logic rd_solid;
        logic cur_moved;
        logic y_last;
        logic x_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== hdl/fsgs_ctrl.sv =====
// controller state machine: clearing pass, item decode, sweep sequencing
`timescale 1ns / 1ps
`default_nettype none
module fsgs_ctrl
    import fsgs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    output logic         o_s_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.asel = A_IN;
        o_cmd.wsel = W_CLEAR;
        o_cmd.osel = O_READ;
        unique case (r_state)
            S_CLR: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.wsel    = W_CLEAR;
                o_cmd.asel    = A_CLR;
                o_cmd.clr_inc = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_read) begin
                    n_state = S_OUT_RD;
                end else begin
                    o_cmd.cnt_upd = 1'b1;
                    if (i_sts.paint_ok) begin
                        o_cmd.mem_we = 1'b1;
                        o_cmd.wsel   = W_PAINT;
                    end
                    n_state = i_sts.sweep_go ? S_SW_INIT : S_OUT_FR;
                end
            end
            S_SW_INIT: begin
                o_cmd.sw_init = 1'b1;
                n_state       = S_SW_RC;
            end
            S_SW_RC: begin
                o_cmd.asel = A_C;
                n_state    = S_SW_EC;
            end
            S_SW_EC: begin
                // air or an already moved grain is skipped
                if (!i_sts.rd_solid || i_sts.cur_moved) begin
                    n_state = S_SW_NEXT;
                end else begin
                    o_cmd.keep_color = 1'b1;
                    o_cmd.asel       = A_D;
                    n_state          = S_SW_ED;
                end
            end
            S_SW_ED: begin
                if (!i_sts.rd_solid) begin
                    o_cmd.mem_we     = 1'b1;
                    o_cmd.wsel       = W_DST;
                    o_cmd.asel       = A_D;
                    o_cmd.set_cur_mv = 1'b1;
                    n_state          = S_SW_WS;
                end else begin
                    o_cmd.asel = A_DR;
                    n_state    = S_SW_EDR;
                end
            end
            S_SW_EDR: begin
                if (!i_sts.rd_solid) begin
                    o_cmd.mem_we     = 1'b1;
                    o_cmd.wsel       = W_DST;
                    o_cmd.asel       = A_DR;
                    o_cmd.set_nxt_mv = 1'b1;
                    n_state          = S_SW_WS;
                end else begin
                    o_cmd.asel = A_DL;
                    n_state    = S_SW_EDL;
                end
            end
            S_SW_EDL: begin
                if (!i_sts.rd_solid) begin
                    o_cmd.mem_we = 1'b1;
                    o_cmd.wsel   = W_DST;
                    o_cmd.asel   = A_DL;
                    n_state      = S_SW_WS;
                end else begin
                    n_state = S_SW_NEXT;
                end
            end
            S_SW_WS: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = W_SRC;
                o_cmd.asel   = A_C;
                n_state      = S_SW_NEXT;
            end
            S_SW_NEXT: begin
                o_cmd.step = 1'b1;
                n_state    = (i_sts.y_last && i_sts.x_last) ? S_OUT_SW : S_SW_RC;
            end
            S_OUT_RD: begin
                o_cmd.osel = O_READ;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_OUT_FR: begin
                o_cmd.osel = O_FRAME;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_OUT_SW: begin
                o_cmd.osel = O_SWEPT;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/fsgs_dp.sv =====
// datapath: cell memory, frame counter, sweep position, moved flags, result register
`timescale 1ns / 1ps
`default_nettype none
module fsgs_dp
    import fsgs_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_cfg_valid,
    input  wire logic [PERW-1:0]       i_cfg_data,
    input  wire logic                  i_s_tuser,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic                       o_m_tuser,
    output logic [M_TDATA_W-1:0]       o_m_tdata
);

    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam logic [AW-1:0] GY_A     = AW'(GRID_Y);
    localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
    localparam logic [XW-1:0] X_LAST   = XW'(GRID_X - 2);
    localparam logic [YW-1:0] Y_LAST   = YW'(GRID_Y - 2);
    localparam logic [CW:0]   GX_C     = (CW + 1)'(GRID_X);
    localparam logic [CW:0]   GY_C     = (CW + 1)'(GRID_Y);
    localparam int PAD_W = M_TDATA_W - (COLW + 2);

    logic [MW-1:0]   r_mem [DEPTH];
    logic [MW-1:0]   r_rd;

    logic            r_is_read;
    logic            r_paint;
    logic [CW-1:0]   r_in_x;
    logic [CW-1:0]   r_in_y;
    logic [COLW-1:0] r_in_color;

    logic [PERW-1:0] r_period;
    logic [PERW-1:0] r_cnt;
    logic [PERW-1:0] n_cnt;
    logic [AW-1:0]   r_clr_addr;

    logic [XW-1:0]   r_x;
    logic [YW-1:0]   r_y;
    logic [COLW-1:0] r_color;
    logic [GRID_Y-1:0] r_cur_mv;
    logic [GRID_Y-1:0] r_nxt_mv;

    logic            r_out_valid;
    logic            r_out_kind;
    logic            r_out_solid;
    logic [COLW-1:0] r_out_color;
    logic            r_out_swept;

    logic            in_bounds;
    logic [XW-1:0]   ax;
    logic [YW-1:0]   ay;
    logic [AW-1:0]   addr;
    logic [MW-1:0]   wdata;

    assign in_bounds = ({1'b0, r_in_x} < GX_C) && ({1'b0, r_in_y} < GY_C);

    // counter returns to zero once past the period, then steps
    always_comb begin
        n_cnt = ((r_cnt > r_period) ? '0 : r_cnt) + PERW'(1);
    end

    always_comb begin
        ax = r_x;
        ay = r_y;
        unique case (i_cmd.asel)
            A_IN: begin
                ax = XW'(r_in_x);
                ay = YW'(r_in_y);
            end
            A_C: begin
                ax = r_x;
                ay = r_y;
            end
            A_D: begin
                ax = r_x;
                ay = r_y + YW'(1);
            end
            A_DR: begin
                ax = r_x + XW'(1);
                ay = r_y + YW'(1);
            end
            A_DL: begin
                ax = r_x - XW'(1);
                ay = r_y + YW'(1);
            end
            default: begin
                ax = r_x;
                ay = r_y;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.asel == A_CLR) begin
            addr = r_clr_addr;
        end else if (i_cmd.asel == A_IN && !in_bounds) begin
            addr = '0;
        end else begin
            addr = AW'(ax) * GY_A + AW'(ay);
        end
    end

    always_comb begin
        unique case (i_cmd.wsel)
            W_CLEAR: wdata = {1'b0, RESET_COLOR};
            W_PAINT: wdata = {1'b1, r_in_color};
            W_DST:   wdata = {1'b1, r_color};
            W_SRC:   wdata = {1'b0, r_color};
            default: wdata = {1'b0, RESET_COLOR};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[addr] <= wdata;
        end
        r_rd <= r_mem[addr];
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_is_read  <= i_s_tuser;
            r_paint    <= i_s_tdata[0];
            r_in_x     <= i_s_tdata[CW:1];
            r_in_y     <= i_s_tdata[2*CW:CW+1];
            r_in_color <= i_s_tdata[2*CW+COLW:2*CW+1];
        end
        if (i_cmd.keep_color) begin
            r_color <= r_rd[COLW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RESET;
            r_cnt      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (i_cmd.cnt_upd) begin
                r_cnt <= n_cnt;
            end
            if (i_cmd.clr_inc) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // sweep position and moved flags of the current and next column
    always_ff @(posedge i_clk) begin
        if (i_cmd.sw_init) begin
            r_x      <= XW'(1);
            r_y      <= YW'(1);
            r_cur_mv <= '0;
            r_nxt_mv <= '0;
        end else begin
            if (i_cmd.set_cur_mv) begin
                r_cur_mv[r_y + YW'(1)] <= 1'b1;
            end
            if (i_cmd.set_nxt_mv) begin
                r_nxt_mv[r_y + YW'(1)] <= 1'b1;
            end
            if (i_cmd.step) begin
                if (r_y == Y_LAST) begin
                    r_y      <= YW'(1);
                    r_cur_mv <= r_nxt_mv;
                    r_nxt_mv <= '0;
                    if (r_x != X_LAST) begin
                        r_x <= r_x + XW'(1);
                    end
                end else begin
                    r_y <= r_y + YW'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.osel)
                O_READ: begin
                    r_out_kind  <= 1'b1;
                    r_out_solid <= in_bounds & r_rd[COLW];
                    r_out_color <= in_bounds ? r_rd[COLW-1:0] : '0;
                    r_out_swept <= 1'b0;
                end
                O_FRAME: begin
                    r_out_kind  <= 1'b0;
                    r_out_solid <= 1'b0;
                    r_out_color <= '0;
                    r_out_swept <= 1'b0;
                end
                O_SWEPT: begin
                    r_out_kind  <= 1'b0;
                    r_out_solid <= 1'b0;
                    r_out_color <= '0;
                    r_out_swept <= 1'b1;
                end
                default: begin
                    r_out_kind  <= 1'b0;
                    r_out_solid <= 1'b0;
                    r_out_color <= '0;
                    r_out_swept <= 1'b0;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_swept, r_out_color, r_out_solid};

    always_comb begin
        o_sts.is_read   = r_is_read;
        o_sts.paint_ok  = r_paint && (n_cnt > r_period) && in_bounds;
        o_sts.sweep_go  = (n_cnt >= r_period);
        o_sts.clr_last  = (r_clr_addr == LAST_A);
        o_sts.rd_solid  = r_rd[COLW];
        o_sts.cur_moved = r_cur_mv[r_y];
        o_sts.y_last    = (r_y == Y_LAST);
        o_sts.x_last    = (r_x == X_LAST);
        o_sts.out_free  = !r_out_valid || i_m_tready;
    end

endmodule
`default_nettype wire

// ===== hdl/falling_sand_grid_sweep.sv =====
// Falling sand grid sweep: read items return a cell, frame items paint and may sweep the grid.
// A sweeping frame visits (GRID_X-2)*(GRID_Y-2) cells through the single port cell memory
// (one access per cycle, registered read).
// One item is in work at a time; a finished result waits in the output register.
// After reset a clearing pass writes all GRID_X*GRID_Y cells with air
// while s_axis_tready stays low; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module falling_sand_grid_sweep
    import fsgs_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [PERW-1:0]       i_cfg_data,     // sweep_period
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic                  s_axis_tuser,   // cmd
    // paint_enable, cell_x, cell_y, paint_color, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic                       m_axis_tuser,   // reply_kind
    // cell_solid, cell_color, swept, zero pad
    output logic [M_TDATA_W-1:0]       m_axis_tdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    fsgs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    fsgs_dp #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tdata   (s_axis_tdata),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== bench/tb_falling_sand_grid_sweep.sv =====
// testbench of the falling sand grid sweep: directed and random items against a grid predictor
`timescale 1ns / 1ps
module tb_falling_sand_grid_sweep;
    import fsgs_pkg::*;

    localparam int GX = GRID_X_DEF;
    localparam int GY = GRID_Y_DEF;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_READ  = 1'b1
    } t_sand_cmd;

    typedef enum logic {
        REPLY_FRAME = 1'b0,
        REPLY_CELL  = 1'b1
    } t_reply_kind;

    typedef struct {
        t_sand_cmd        cmd;
        logic             paint;
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [COLW-1:0]  colour;
    } t_sand_item;

    typedef struct {
        t_reply_kind      kind;
        logic             solid;
        logic [COLW-1:0]  colour;
        logic             swept;
    } t_sand_reply;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [PERW-1:0]        i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic                   s_axis_tuser = 1'b0;     // cmd
    // paint_enable, cell_x, cell_y, paint_color, zero pad
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   m_axis_tuser;            // reply_kind
    // cell_solid, cell_color, swept, zero pad
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    // predicted grid and frame state
    bit                     grain [GX][GY];
    bit                     moved [GX][GY];
    logic [COLW-1:0]        hue [GX][GY];
    logic [PERW-1:0]        frame_cnt;
    logic [PERW-1:0]        period;

    t_sand_reply            pending [$];
    int                     errors = 0;
    bit                     tx_steady = 1'b0;
    bit                     rx_steady = 1'b0;

    falling_sand_grid_sweep #(
        .GRID_X (GX),
        .GRID_Y (GY)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #150_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic flag_error(input string what);
        errors++;
        if (errors <= 10) begin
            $display("%s", what);
        end
    endtask

    function automatic void clear_grid();
        for (int x = 0; x < GX; x++) begin
            for (int y = 0; y < GY; y++) begin
                grain[x][y] = 1'b0;
                moved[x][y] = 1'b0;
                hue[x][y]   = RESET_COLOR;
            end
        end
        frame_cnt = '0;
        period    = PERIOD_RESET;
    endfunction

    function automatic bit try_fall(input int sx, input int sy, input int dx, input int dy);
        if (grain[dx][dy]) begin
            return 1'b0;
        end
        grain[dx][dy] = 1'b1;
        moved[dx][dy] = 1'b1;
        hue[dx][dy]   = hue[sx][sy];
        // vacated cell turns to air but keeps its colour
        grain[sx][sy] = 1'b0;
        moved[sx][sy] = 1'b1;
        return 1'b1;
    endfunction

    function automatic void sweep_interior();
        for (int x = 0; x < GX; x++) begin
            for (int y = 0; y < GY; y++) begin
                moved[x][y] = 1'b0;
            end
        end
        for (int x = 1; x <= GX - 2; x++) begin
            for (int y = 1; y <= GY - 2; y++) begin
                if (!grain[x][y] || moved[x][y]) begin
                    continue;
                end
                if (try_fall(x, y, x, y + 1)) begin
                    continue;
                end
                if (try_fall(x, y, x + 1, y + 1)) begin
                    continue;
                end
                void'(try_fall(x, y, x - 1, y + 1));
            end
        end
    endfunction

    function automatic t_sand_reply advance_grid(input t_sand_item it);
        t_sand_reply r;
        bit          in_grid;
        r.kind   = REPLY_FRAME;
        r.solid  = 1'b0;
        r.colour = '0;
        r.swept  = 1'b0;
        in_grid  = (it.x < GX) && (it.y < GY);
        if (it.cmd == CMD_READ) begin
            r.kind = REPLY_CELL;
            if (in_grid) begin
                r.solid  = grain[it.x][it.y];
                r.colour = hue[it.x][it.y];
            end
            return r;
        end
        if (frame_cnt > period) begin
            frame_cnt = '0;
        end
        frame_cnt = frame_cnt + 1'b1;
        if (it.paint && frame_cnt > period && in_grid) begin
            grain[it.x][it.y] = 1'b1;
            hue[it.x][it.y]   = it.colour;
        end
        if (frame_cnt >= period) begin
            sweep_interior();
            r.swept = 1'b1;
        end
        return r;
    endfunction

    function automatic t_sand_item mk(input t_sand_cmd cmd, input logic paint, input int x,
                                      input int y, input logic [COLW-1:0] colour);
        t_sand_item it;
        it.cmd    = cmd;
        it.paint  = paint;
        it.x      = x[CW-1:0];
        it.y      = y[CW-1:0];
        it.colour = colour;
        return it;
    endfunction

    task automatic send_item(input t_sand_item it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {{(S_TDATA_W - COLW - 2 * CW - 1){1'b0}}, it.colour, it.y, it.x,
                          it.paint};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pending.push_back(advance_grid(it));
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_period(input logic [PERW-1:0] value);
        drain_replies();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        period = value;
    endtask

    // result side
    initial begin : reply_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin : reply_check
        t_sand_reply          want;
        logic [M_TDATA_W-1:0] want_data;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                flag_error($sformatf("unexpected reply: kind %0d data %08h",
                                     m_axis_tuser, m_axis_tdata));
            end else begin
                want      = pending.pop_front();
                want_data = {{(M_TDATA_W - COLW - 2){1'b0}}, want.swept, want.colour,
                             want.solid};
                if (m_axis_tuser !== want.kind || m_axis_tdata !== want_data) begin
                    flag_error($sformatf({"reply mismatch: kind %0d/%0d solid %0d/%0d ",
                        "colour %06h/%06h swept %0d/%0d data %08h/%08h (exp/got)"},
                        want.kind, m_axis_tuser, want.solid, m_axis_tdata[0],
                        want.colour, m_axis_tdata[COLW:1], want.swept, m_axis_tdata[COLW+1],
                        want_data, m_axis_tdata));
                end
            end
        end
    end

    // grid straight after reset, out of range reads, read ignores paint fields
    task automatic test_reset_contents();
        send_item(mk(CMD_READ, 1'b0, 0, 0, 24'h000000));
        send_item(mk(CMD_READ, 1'b1, GX - 1, GY - 1, 24'hFFFFFF));
        send_item(mk(CMD_READ, 1'b1, GX, 0, 24'hFFFFFF));
        send_item(mk(CMD_READ, 1'b0, 0, GY, 24'h000000));
        send_item(mk(CMD_READ, 1'b0, 255, 255, 24'h000000));
    endtask

    // period 0 paints and sweeps on every frame: build a pile, paint edges and out of range
    task automatic test_paint_and_pile();
        logic [COLW-1:0] shades [6];
        shades = '{24'h000000, 24'hFFFFFF, 24'h123456, 24'hA5A5A5, 24'h5A5A5A, 24'hFF0000};
        set_period(8'd0);
        foreach (shades[i]) begin
            send_item(mk(CMD_FRAME, 1'b1, 20, GY - 4, shades[i]));
        end
        send_item(mk(CMD_FRAME, 1'b1, 0, 0, 24'h00FF00));
        send_item(mk(CMD_FRAME, 1'b1, GX - 1, 40, 24'h0000FF));
        send_item(mk(CMD_FRAME, 1'b1, GX, 10, 24'hABCDEF));
        send_item(mk(CMD_FRAME, 1'b1, 10, GY, 24'hABCDEF));
        send_item(mk(CMD_FRAME, 1'b0, 30, 30, 24'h777777));
        send_item(mk(CMD_READ, 1'b0, 20, GY - 1, 24'h0));
        send_item(mk(CMD_READ, 1'b0, 19, GY - 1, 24'h0));
        send_item(mk(CMD_READ, 1'b0, 21, GY - 1, 24'h0));
        send_item(mk(CMD_READ, 1'b0, 20, GY - 2, 24'h0));
        send_item(mk(CMD_READ, 1'b0, 20, GY - 4, 24'h0));
        send_item(mk(CMD_READ, 1'b0, 0, 0, 24'h0));
        send_item(mk(CMD_READ, 1'b0, GX - 1, 40, 24'h0));
        send_item(mk(CMD_READ, 1'b0, 30, 30, 24'h0));
    endtask

    // counter climbs to 255 under period 254, then period 255 wraps it to 0 without painting
    task automatic test_counter_wrap();
        set_period(8'd254);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        while (frame_cnt != 8'd254) begin
            send_item(mk(CMD_FRAME, 1'b0, 0, 0, 24'h0));
        end
        send_item(mk(CMD_FRAME, 1'b1, 30, 30, 24'hC0FFEE));
        set_period(8'd255);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        send_item(mk(CMD_FRAME, 1'b1, 31, 30, 24'h111111));
        send_item(mk(CMD_FRAME, 1'b1, 31, 30, 24'h222222));
        send_item(mk(CMD_READ, 1'b0, 30, 30, 24'h0));
        send_item(mk(CMD_READ, 1'b0, 30, 31, 24'h0));
        send_item(mk(CMD_READ, 1'b0, 31, 30, 24'h0));
    endtask

    // phases of random items: mostly grains dropped near one column and reads around it
    task automatic test_random_phases();
        logic [PERW-1:0] settings [6];
        int              cx;
        int              pick;
        settings = '{8'd0, 8'd1, PERW'($urandom_range(2, 5)), PERW'($urandom_range(0, 254)),
                     8'd1, 8'd0};
        foreach (settings[ph]) begin
            set_period(settings[ph]);
            tx_steady = (ph == 2) || (ph == 5);
            rx_steady = (ph == 4) || (ph == 5);
            cx = $urandom_range(3, GX - 4);
            for (int n = 0; n < 17; n++) begin
                if ($urandom_range(0, 15) == 0) begin
                    drain_replies();
                end
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    send_item(mk(CMD_FRAME, 1'b1, cx + $urandom_range(0, 4) - 2,
                                 $urandom_range(GY - 8, GY - 6),
                                 COLW'($urandom_range(0, 24'hFFFFFF))));
                end else if (pick < 7) begin
                    send_item(mk(CMD_READ, 1'($urandom_range(0, 1)),
                                 cx + $urandom_range(0, 6) - 3,
                                 $urandom_range(GY - 8, GY - 1),
                                 COLW'($urandom_range(0, 24'hFFFFFF))));
                end else begin
                    send_item(mk(t_sand_cmd'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 COLW'($urandom_range(0, 24'hFFFFFF))));
                end
            end
        end
    endtask

    initial begin
        clear_grid();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_contents();
        test_paint_and_pile();
        test_counter_wrap();
        test_random_phases();
        drain_replies();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
